@@ src/tlel_pkg.sv @@
// Package for the throttled LRU eviction list: opcodes, status codes, sequencer states.
// No dependencies.
`default_nettype none
package tlel_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TOUCH  = 2'd2,
    OP_EVICT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_LISTING  = 2'd1,
    ST_SKIPPED  = 2'd2,
    ST_NO_VICTIM = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_APPEND,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

@@ src/throttled_lru_evict_list.sv @@
// Throttled LRU eviction list, top level and only module.
// Depends on tlel_pkg.
//
// One operation is in flight at a time. Each passes through the sequencer states in
// order: a rejected request or an evict on an empty list goes from check to output,
// add goes check, append, output, remove and a successful evict go check, scan, shift,
// output, touch goes check, scan, shift, append, output, and an evict that finds no
// idle entry goes check, scan, output. The search reads one slot per cycle and stops
// at the hit, then one slot moves down per cycle to close the gap. The slot memory
// gives one registered read and one write per cycle, which sets that pace. The
// result sits in an output register and the block takes no new item until it has
// been transferred.
`default_nettype none
module throttled_lru_evict_list #(
  parameter int ENTRY_COUNT = 64,
  parameter int TIME_BITS   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,     // touch_interval
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // op[1:0], entry[7:2], now[39:8], incomplete[40], busy_mask[104:41], zero pad
  input  wire logic [111:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], victim[7:2], listed_count[14:8], zero pad
  output logic [15:0]      out_tdata
);

  localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CW = $clog2(ENTRY_COUNT + 1);

  // Stores
  logic [5:0]           slot_mem [ENTRY_COUNT];
  logic [TIME_BITS-1:0] time_mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] listed_r, listed_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0] intv_r;

  tlel_pkg::state_t state_r, state_nxt;
  tlel_pkg::op_t op_r;
  logic [5:0]  ent_r;
  logic [31:0] now_r;
  logic        inc_r;
  logic [63:0] busy_r;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [5:0]  slot_q;          // registered slot read
  logic [TIME_BITS-1:0] time_q; // registered time read
  logic [1:0]  stat_r, stat_nxt;
  logic [5:0]  vic_r, vic_nxt;
  logic [5:0]  tgt_r, tgt_nxt;  // entry being unlinked
  logic        rd_valid_r;      // slot_q matches pos_r - 1 read

  logic ent_ok;
  logic [TIME_BITS-1:0] now_t, elapsed;
  logic [IW-1:0] ent_idx;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == tlel_pkg::S_IDLE);
  assign out_tvalid = (state_r == tlel_pkg::S_OUT);
  assign out_tdata = {1'b0, 7'(cnt_r), vic_r, stat_r};

  assign ent_ok  = ({26'd0, ent_r} < ENTRY_COUNT);
  assign ent_idx = ent_r[IW-1:0];
  assign now_t   = TIME_BITS'({32'd0, now_r});
  assign elapsed = now_t - time_q;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intv_r <= 16'd2;
    end else if (cfg_valid && cfg_ready) begin
      intv_r <= cfg_data;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= tlel_pkg::op_t'(in_tdata[1:0]);
      ent_r  <= in_tdata[7:2];
      now_r  <= in_tdata[39:8];
      inc_r  <= in_tdata[40];
      busy_r <= in_tdata[104:41];
    end
  end

  // Memory reads and writes; one slot read per cycle at pos, time read ready in check
  always_ff @(posedge clk) begin
    slot_q <= slot_mem[pos_r[IW-1:0]];
    time_q <= time_mem[(state_r == tlel_pkg::S_IDLE) ? in_tdata[2 +: IW] : ent_idx];
    if (state_r == tlel_pkg::S_SHIFT && rd_valid_r)
      slot_mem[IW'(pos_r - CW'(2))] <= slot_q;
    if (state_r == tlel_pkg::S_APPEND)
      slot_mem[IW'(cnt_r)] <= ent_r;
    if (state_r == tlel_pkg::S_CHECK && ent_ok && op_r == tlel_pkg::OP_ADD
        && !listed_r[ent_idx])
      time_mem[ent_idx] <= now_t;
    if (state_r == tlel_pkg::S_CHECK && op_r == tlel_pkg::OP_TOUCH && !inc_r && ent_ok
        && listed_r[ent_idx] && !(elapsed < TIME_BITS'(intv_r)))
      time_mem[ent_idx] <= now_t;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlel_pkg::S_IDLE:   if (in_tvalid) state_nxt = tlel_pkg::S_CHECK;
      tlel_pkg::S_CHECK: begin
        priority if (op_r == tlel_pkg::OP_ADD) begin
          state_nxt = (ent_ok && !listed_r[ent_idx]) ? tlel_pkg::S_APPEND : tlel_pkg::S_OUT;
        end else if (op_r == tlel_pkg::OP_REMOVE) begin
          state_nxt = (ent_ok && listed_r[ent_idx]) ? tlel_pkg::S_SCAN : tlel_pkg::S_OUT;
        end else if (op_r == tlel_pkg::OP_TOUCH) begin
          state_nxt = (!inc_r && ent_ok && listed_r[ent_idx]
                       && !(elapsed < TIME_BITS'(intv_r))) ? tlel_pkg::S_SCAN
                                                           : tlel_pkg::S_OUT;
        end else begin
          state_nxt = (cnt_r == '0) ? tlel_pkg::S_OUT : tlel_pkg::S_SCAN;
        end
      end
      tlel_pkg::S_SCAN: begin
        // slot_q holds slot pos_r - 1
        priority if (op_r == tlel_pkg::OP_EVICT ? !busy_r[slot_q] : (slot_q == tgt_r))
          state_nxt = tlel_pkg::S_SHIFT;
        else if (pos_r == cnt_r)
          state_nxt = tlel_pkg::S_OUT;
        else
          state_nxt = tlel_pkg::S_SCAN;
      end
      tlel_pkg::S_SHIFT: begin
        if (pos_r > cnt_r)
          state_nxt = (op_r == tlel_pkg::OP_TOUCH) ? tlel_pkg::S_APPEND : tlel_pkg::S_OUT;
      end
      tlel_pkg::S_APPEND: state_nxt = tlel_pkg::S_OUT;
      tlel_pkg::S_OUT:    if (out_tready) state_nxt = tlel_pkg::S_IDLE;
      default:            state_nxt = tlel_pkg::S_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    listed_nxt = listed_r;
    stat_nxt   = stat_r;
    vic_nxt    = vic_r;
    tgt_nxt    = tgt_r;
    unique case (state_r)
      tlel_pkg::S_IDLE: begin
        pos_nxt = '0;
        if (in_tvalid) begin
          stat_nxt = tlel_pkg::ST_DONE;
          vic_nxt  = '0;
          tgt_nxt  = in_tdata[7:2];
        end
      end
      tlel_pkg::S_CHECK: begin
        pos_nxt = CW'(1);
        priority if (op_r == tlel_pkg::OP_ADD) begin
          if (!(ent_ok && !listed_r[ent_idx])) stat_nxt = tlel_pkg::ST_LISTING;
          else listed_nxt[ent_idx] = 1'b1;
        end else if (op_r == tlel_pkg::OP_REMOVE) begin
          if (!(ent_ok && listed_r[ent_idx])) stat_nxt = tlel_pkg::ST_LISTING;
          else listed_nxt[ent_idx] = 1'b0;
        end else if (op_r == tlel_pkg::OP_TOUCH) begin
          priority if (inc_r) stat_nxt = tlel_pkg::ST_SKIPPED;
          else if (!(ent_ok && listed_r[ent_idx])) stat_nxt = tlel_pkg::ST_LISTING;
          else if (elapsed < TIME_BITS'(intv_r)) stat_nxt = tlel_pkg::ST_SKIPPED;
          else stat_nxt = tlel_pkg::ST_DONE;
        end else begin
          if (cnt_r == '0) stat_nxt = tlel_pkg::ST_NO_VICTIM;
        end
      end
      tlel_pkg::S_SCAN: begin
        priority if (op_r == tlel_pkg::OP_EVICT ? !busy_r[slot_q] : (slot_q == tgt_r)) begin
          pos_nxt = pos_r + CW'(1);
          if (op_r == tlel_pkg::OP_EVICT) begin
            vic_nxt = slot_q;
            if ({26'd0, slot_q} < ENTRY_COUNT) listed_nxt[slot_q[IW-1:0]] = 1'b0;
          end
        end else if (pos_r == cnt_r) begin
          stat_nxt = tlel_pkg::ST_NO_VICTIM;
        end else begin
          pos_nxt = pos_r + CW'(1);
        end
      end
      tlel_pkg::S_SHIFT: begin
        pos_nxt = pos_r + CW'(1);
        if (pos_r > cnt_r) cnt_nxt = cnt_r - CW'(1);
      end
      tlel_pkg::S_APPEND: cnt_nxt = cnt_r + CW'(1);
      tlel_pkg::S_OUT: ;
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tlel_pkg::S_IDLE;
      cnt_r      <= '0;
      listed_r   <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      listed_r   <= listed_nxt;
      // shift writes slot pos-2 with slot pos-1 read last cycle, only once past the hit
      rd_valid_r <= (state_nxt == tlel_pkg::S_SHIFT) && (state_r == tlel_pkg::S_SHIFT)
                    ? (pos_r <= cnt_r) : (state_nxt == tlel_pkg::S_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    stat_r <= stat_nxt;
    vic_r  <= vic_nxt;
    tgt_r  <= tgt_nxt;
  end

endmodule
`default_nettype wire
